// ===== design/tmlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmlp_pkg: shared types and constants of the tiny MLP trainer
// Request payload types, register indexes, shared-unit operation and saturation.
// ----------------------------------------------------------------------------
package tmlp_pkg;

    localparam int DATA_W  = 16;
    localparam int OPB_W   = DATA_W + 1;
    localparam int PROD_W  = DATA_W + OPB_W;
    localparam int LR_BITS = 16;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_LEARNING_RATE = 3'd0;
    localparam cfg_idx_t REG_HIDDEN_W00    = 3'd1;
    localparam cfg_idx_t REG_HIDDEN_W01    = 3'd2;
    localparam cfg_idx_t REG_HIDDEN_W10    = 3'd3;
    localparam cfg_idx_t REG_HIDDEN_W11    = 3'd4;
    localparam cfg_idx_t REG_OUT_W0        = 3'd5;
    localparam cfg_idx_t REG_OUT_W1        = 3'd6;

    localparam logic signed [DATA_W-1:0] INIT_WEIGHT = 16'sd2048;
    localparam logic [LR_BITS-1:0]       INIT_LR     = 16'd66;
    localparam logic signed [DATA_W-1:0] SAT_MAX     = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN     = 16'sh8000;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] x_first;
        logic signed [DATA_W-1:0] x_second;
        logic signed [DATA_W-1:0] target;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prediction;
        logic signed [DATA_W-1:0] output_error;
    } out_t;

    // One operation of the shared multiply-scale-accumulate unit.
    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [OPB_W-1:0]  b;
        logic                     lr_mode;
        logic signed [DATA_W-1:0] acc;
    } mac_op_t;

    // Clip a 17-bit sum or difference to the signed 16-bit range.
    function automatic logic signed [DATA_W-1:0] sat17(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
        begin
            return v[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== design/tiny_mlp_relu_sgd_trainer.sv =====
// ----------------------------------------------------------------------------
// tiny_mlp_relu_sgd_trainer: 2-2-1 ReLU network with on-line gradient descent
// Forward pass, error and one backpropagation step through one shared unit.
// ----------------------------------------------------------------------------
// A request carries two Q4.12 inputs, a target and a kind. The block answers
// every request with one result holding the prediction made with the current
// weights and, on a training request, the saturated error target minus
// prediction (zero on inference). A training request then updates all six
// weights by one step of backpropagation with the programmed learning rate.
// All arithmetic runs through a single multiplier followed by a scale,
// saturate and accumulate stage; each multiply has an issue state and a
// write-back state. An inference request runs six multiplies and then
// presents the result; a training request runs 20 multiplies and an error
// step before presenting the result. The block takes one request at a
// time and is ready again once the result has been taken.
// Writing an initial-weight register loads that weight immediately; writes
// should only happen while the block is idle.
module tiny_mlp_relu_sgd_trainer #(
    parameter int FRAC_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tmlp_pkg::in_t          in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tmlp_pkg::out_t         out_data,
    input  logic                  cfg_write,
    input  tmlp_pkg::cfg_idx_t     cfg_index,
    input  logic [tmlp_pkg::DATA_W-1:0] cfg_data
);
    import tmlp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_WB   = 5'b00100,
        S_ERR  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef logic [4:0] step_t;

    // Sequence of shared-unit operations. Deltas are formed before the output
    // weights change so that backpropagation sees the old output weights.
    localparam step_t STEP_PRE0_A  = 5'd0;
    localparam step_t STEP_PRE0_B  = 5'd1;
    localparam step_t STEP_PRE1_A  = 5'd2;
    localparam step_t STEP_PRE1_B  = 5'd3;
    localparam step_t STEP_PRED_A  = 5'd4;
    localparam step_t STEP_PRED_B  = 5'd5;
    localparam step_t STEP_DELTA0  = 5'd6;
    localparam step_t STEP_DELTA1  = 5'd7;
    localparam step_t STEP_V0_G    = 5'd8;
    localparam step_t STEP_V0_UPD  = 5'd9;
    localparam step_t STEP_V1_G    = 5'd10;
    localparam step_t STEP_V1_UPD  = 5'd11;
    localparam step_t STEP_W00_G   = 5'd12;
    localparam step_t STEP_W00_UPD = 5'd13;
    localparam step_t STEP_W01_G   = 5'd14;
    localparam step_t STEP_W01_UPD = 5'd15;
    localparam step_t STEP_W10_G   = 5'd16;
    localparam step_t STEP_W10_UPD = 5'd17;
    localparam step_t STEP_W11_G   = 5'd18;
    localparam step_t STEP_W11_UPD = 5'd19;

    localparam logic signed [DATA_W-1:0] ZERO = '0;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;

    logic [LR_BITS-1:0]       lr_reg, lr_next;
    logic signed [DATA_W-1:0] hw_reg [0:3];
    logic signed [DATA_W-1:0] hw_next [0:3];
    logic signed [DATA_W-1:0] ow_reg [0:1];
    logic signed [DATA_W-1:0] ow_next [0:1];

    logic                     kind_reg, kind_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] x1_reg, x1_next;
    logic signed [DATA_W-1:0] target_reg, target_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] pre0_reg, pre0_next;
    logic signed [DATA_W-1:0] pre1_reg, pre1_next;
    logic signed [DATA_W-1:0] pred_reg, pred_next;
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic signed [DATA_W-1:0] delta0_reg, delta0_next;
    logic signed [DATA_W-1:0] delta1_reg, delta1_next;

    logic                     pos0, pos1;
    logic signed [DATA_W-1:0] h0, h1;
    logic                     issue;
    mac_op_t                  op;
    logic signed [DATA_W-1:0] mac_result;

    // ReLU: a hidden unit passes only a pre-activation above zero.
    assign pos0 = !pre0_reg[DATA_W-1] && (|pre0_reg);
    assign pos1 = !pre1_reg[DATA_W-1] && (|pre1_reg);
    assign h0   = pos0 ? pre0_reg : ZERO;
    assign h1   = pos1 ? pre1_reg : ZERO;

    assign issue     = (state_reg == S_MUL);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data.prediction   = pred_reg;
    assign out_data.output_error = err_reg;

    // Operand selection for the current step. The "G" steps form a gradient
    // term in the temporary register; the "UPD" steps scale it by the rate and
    // add it to the weight being updated.
    always_comb
    begin
        op.a       = ZERO;
        op.b       = '0;
        op.lr_mode = 1'b0;
        op.acc     = ZERO;
        case (step_reg)
            STEP_PRE0_A:
            begin
                op.a = x0_reg;
                op.b = {hw_reg[0][DATA_W-1], hw_reg[0]};
            end
            STEP_PRE0_B:
            begin
                op.a   = x1_reg;
                op.b   = {hw_reg[1][DATA_W-1], hw_reg[1]};
                op.acc = tmp_reg;
            end
            STEP_PRE1_A:
            begin
                op.a = x0_reg;
                op.b = {hw_reg[2][DATA_W-1], hw_reg[2]};
            end
            STEP_PRE1_B:
            begin
                op.a   = x1_reg;
                op.b   = {hw_reg[3][DATA_W-1], hw_reg[3]};
                op.acc = tmp_reg;
            end
            STEP_PRED_A:
            begin
                op.a = h0;
                op.b = {ow_reg[0][DATA_W-1], ow_reg[0]};
            end
            STEP_PRED_B:
            begin
                op.a   = h1;
                op.b   = {ow_reg[1][DATA_W-1], ow_reg[1]};
                op.acc = tmp_reg;
            end
            STEP_DELTA0:
            begin
                op.a = err_reg;
                op.b = {ow_reg[0][DATA_W-1], ow_reg[0]};
            end
            STEP_DELTA1:
            begin
                op.a = err_reg;
                op.b = {ow_reg[1][DATA_W-1], ow_reg[1]};
            end
            STEP_V0_G:
            begin
                op.a = err_reg;
                op.b = {h0[DATA_W-1], h0};
            end
            STEP_V1_G:
            begin
                op.a = err_reg;
                op.b = {h1[DATA_W-1], h1};
            end
            STEP_W00_G:
            begin
                op.a = delta0_reg;
                op.b = {x0_reg[DATA_W-1], x0_reg};
            end
            STEP_W01_G:
            begin
                op.a = delta0_reg;
                op.b = {x1_reg[DATA_W-1], x1_reg};
            end
            STEP_W10_G:
            begin
                op.a = delta1_reg;
                op.b = {x0_reg[DATA_W-1], x0_reg};
            end
            STEP_W11_G:
            begin
                op.a = delta1_reg;
                op.b = {x1_reg[DATA_W-1], x1_reg};
            end
            STEP_V0_UPD, STEP_V1_UPD, STEP_W00_UPD, STEP_W01_UPD,
            STEP_W10_UPD, STEP_W11_UPD:
            begin
                op.a       = tmp_reg;
                op.b       = {1'b0, lr_reg};
                op.lr_mode = 1'b1;
                case (step_reg)
                    STEP_V0_UPD:  op.acc = ow_reg[0];
                    STEP_V1_UPD:  op.acc = ow_reg[1];
                    STEP_W00_UPD: op.acc = hw_reg[0];
                    STEP_W01_UPD: op.acc = hw_reg[1];
                    STEP_W10_UPD: op.acc = hw_reg[2];
                    default:      op.acc = hw_reg[3];
                endcase
            end
            default:
            begin
                op.a = ZERO;
            end
        endcase
    end

    tmlp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .issue  (issue),
        .op     (op),
        .result (mac_result)
    );

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        lr_next     = lr_reg;
        hw_next     = hw_reg;
        ow_next     = ow_reg;
        kind_next   = kind_reg;
        x0_next     = x0_reg;
        x1_next     = x1_reg;
        target_next = target_reg;
        tmp_next    = tmp_reg;
        pre0_next   = pre0_reg;
        pre1_next   = pre1_reg;
        pred_next   = pred_reg;
        err_next    = err_reg;
        delta0_next = delta0_reg;
        delta1_next = delta1_reg;

        // Register writes must arrive only while idle; the block itself does not enforce it.
        if (cfg_write)
        begin
            case (cfg_index)
                REG_LEARNING_RATE: lr_next    = cfg_data;
                REG_HIDDEN_W00:    hw_next[0] = cfg_data;
                REG_HIDDEN_W01:    hw_next[1] = cfg_data;
                REG_HIDDEN_W10:    hw_next[2] = cfg_data;
                REG_HIDDEN_W11:    hw_next[3] = cfg_data;
                REG_OUT_W0:        ow_next[0] = cfg_data;
                REG_OUT_W1:        ow_next[1] = cfg_data;
                default:           lr_next    = lr_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = in_data.kind;
                    x0_next     = in_data.x_first;
                    x1_next     = in_data.x_second;
                    target_next = in_data.target;
                    step_next   = STEP_PRE0_A;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_MUL;
                step_next  = step_reg + step_t'(1);
                case (step_reg)
                    STEP_PRE0_B:  pre0_next   = mac_result;
                    STEP_PRE1_B:  pre1_next   = mac_result;
                    STEP_DELTA0:  delta0_next = pos0 ? mac_result : ZERO;
                    STEP_DELTA1:  delta1_next = pos1 ? mac_result : ZERO;
                    STEP_V0_UPD:  ow_next[0]  = mac_result;
                    STEP_V1_UPD:  ow_next[1]  = mac_result;
                    STEP_W00_UPD: hw_next[0]  = mac_result;
                    STEP_W01_UPD: hw_next[1]  = mac_result;
                    STEP_W10_UPD: hw_next[2]  = mac_result;
                    STEP_W11_UPD: hw_next[3]  = mac_result;
                    STEP_PRED_B:  pred_next   = mac_result;
                    default:      tmp_next    = mac_result;
                endcase
                if (step_reg == STEP_PRED_B)
                begin
                    if (kind_reg)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        err_next   = ZERO;
                        state_next = S_DONE;
                    end
                end
                else if (step_reg == STEP_W11_UPD)
                begin
                    state_next = S_DONE;
                end
            end
            S_ERR:
            begin
                err_next   = sat17({target_reg[DATA_W-1], target_reg} -
                                   {pred_reg[DATA_W-1], pred_reg});
                state_next = S_MUL;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, learning rate and weights.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= STEP_PRE0_A;
            lr_reg    <= INIT_LR;
            hw_reg[0] <= INIT_WEIGHT;
            hw_reg[1] <= INIT_WEIGHT;
            hw_reg[2] <= INIT_WEIGHT;
            hw_reg[3] <= INIT_WEIGHT;
            ow_reg[0] <= INIT_WEIGHT;
            ow_reg[1] <= INIT_WEIGHT;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            lr_reg    <= lr_next;
            hw_reg    <= hw_next;
            ow_reg    <= ow_next;
        end
    end

    // Request fields and intermediate values.
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        target_reg <= target_next;
        tmp_reg    <= tmp_next;
        pre0_reg   <= pre0_next;
        pre1_reg   <= pre1_next;
        pred_reg   <= pred_next;
        err_reg    <= err_next;
        delta0_reg <= delta0_next;
        delta1_reg <= delta1_next;
    end

endmodule

// ===== design/tmlp_mac.sv =====
// ----------------------------------------------------------------------------
// tmlp_mac: shared multiply, scale and saturating accumulate unit
// The product is registered on issue; the following cycle scales it and adds it.
// ----------------------------------------------------------------------------
module tmlp_mac #(
    parameter int FRAC_BITS = 12
) (
    input  logic             clk,
    input  logic             issue,
    input  tmlp_pkg::mac_op_t op,
    output logic signed [tmlp_pkg::DATA_W-1:0] result
);
    import tmlp_pkg::*;

    localparam int SH_W = PROD_W - FRAC_BITS;

    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] product_next;
    logic signed [SH_W-1:0]   frac_val;
    logic [SH_W-DATA_W:0]     top_bits;
    logic                     ovf;
    logic signed [DATA_W-1:0] frac_sat;
    logic signed [DATA_W-1:0] scaled;

    assign product_next = $signed(op.a) * $signed(op.b);

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            product_reg <= product_next;
        end
    end

    // Dropping the low bits of a two's complement value floors it.
    assign frac_val = product_reg[PROD_W-1:FRAC_BITS];
    assign top_bits = frac_val[SH_W-1:DATA_W-1];
    assign ovf      = !((&top_bits) || (~|top_bits));

    always_comb
    begin
        if (ovf)
        begin
            frac_sat = frac_val[SH_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            frac_sat = frac_val[DATA_W-1:0];
        end
    end

    // A 16-bit value times an unsigned 16-bit rate, shifted by 16, always fits.
    assign scaled = op.lr_mode ? product_reg[LR_BITS +: DATA_W] : frac_sat;
    assign result = sat17({op.acc[DATA_W-1], op.acc} + {scaled[DATA_W-1], scaled});

endmodule
